@@ rtl/svpwm_pkg.sv @@
package svpwm_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_SUPPLY_GAIN = 2'd0;
	localparam logic [1:0] CFG_DUTY_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_PWM_PERIOD  = 2'd2;

	// reset values of the configuration registers
	localparam logic [15:0] SUPPLY_GAIN_RST = 16'd5461;
	localparam logic [15:0] DUTY_LIMIT_RST  = 16'd62259;
	localparam logic [15:0] PWM_PERIOD_RST  = 16'd8500;

	// sqrt3 in Q16
	localparam logic [16:0] SQRT3_Q16 = 17'd113512;

	// x / 3 == (x * 43691) >> 17 for any 16-bit x
	localparam logic [15:0] DIV3_RECIP = 16'd43691;
	localparam int DIV3_SHIFT = 17;

	// one turn of duty in Q16
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef logic [15:0] word16_t;
	typedef logic [2:0]  sec_t;

	// voltage command times supply gain, Q16 volts scaled
	typedef logic [23:0] vg_t;

endpackage

@@ rtl/svpwm_angle_front.sv @@
module svpwm_angle_front #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_LUT_ENTRIES = 1024
) (
	input  logic                               clk,
	input  logic [2:0]                         en,          // loads s1..s3
	input  logic [15:0]                        voltage_cmd,
	input  logic [15:0]                        elec_angle,
	input  svpwm_pkg::word16_t                 supply_gain,
	output logic [$clog2(SINE_LUT_ENTRIES)-1:0] idx1_s3,
	output logic [$clog2(SINE_LUT_ENTRIES)-1:0] idx2_s3,
	output svpwm_pkg::vg_t                     vg_s3,
	output svpwm_pkg::sec_t                    sec_s3
);
	import svpwm_pkg::*;

	localparam int AW   = ANGLE_BITS;
	localparam int LW   = $clog2(SINE_LUT_ENTRIES);
	localparam int NW   = $clog2(SINE_LUT_ENTRIES) + 2;
	localparam int PW   = AW + NW + 1;
	localparam logic [AW:0]   TURN = (AW+1)'(1) << AW;
	localparam logic [NW-1:0] N2   = NW'(2 * SINE_LUT_ENTRIES);

	// stage 1: fold sign into angle, quarter-turn advance, sector split
	logic [AW-1:0] ang_in, ang_neg, ang_adv;
	logic [AW+2:0] ang6;
	logic [16:0]   mag_full;
	logic [15:0]   mag_s1;
	logic [AW-1:0] phi_s1;
	sec_t          sec_s1;

	always_comb begin
		ang_in  = AW'(elec_angle);
		ang_neg = voltage_cmd[15] ? ang_in + AW'(TURN >> 1) : ang_in;
		ang_adv = ang_neg + AW'(TURN >> 2);
		ang6    = ((AW+3)'(ang_adv) << 2) + ((AW+3)'(ang_adv) << 1);
		mag_full = voltage_cmd[15] ? 17'(ONE_Q16 - {1'b0, voltage_cmd})
			: {1'b0, voltage_cmd};
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mag_s1 <= mag_full[15:0];
			phi_s1 <= ang6[AW-1:0];
			sec_s1 <= ang6[AW+2:AW];
		end
	end

	// stage 2: voltage gain and scaled sector position
	logic [31:0]   vg_prod;
	logic [AW:0]   phic;
	logic [PW-1:0] prod1, prod2;
	logic [NW-1:0] z1_s2, z2_s2;
	vg_t           vg_s2;
	sec_t          sec_s2;

	always_comb begin
		vg_prod = 32'(mag_s1) * 32'(supply_gain);
		phic    = TURN - {1'b0, phi_s1};
		prod1   = PW'(phic) * PW'(N2);
		prod2   = PW'(phi_s1) * PW'(N2);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			vg_s2  <= vg_prod[31:8];
			z1_s2  <= prod1[AW+NW-1:AW];
			z2_s2  <= prod2[AW+NW-1:AW];
			sec_s2 <= sec_s1;
		end
	end

	// stage 3: divide by three for the table indexes
	logic [31:0] q1, q2;

	always_comb begin
		q1 = 32'(z1_s2) * 32'(DIV3_RECIP);
		q2 = 32'(z2_s2) * 32'(DIV3_RECIP);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			idx1_s3 <= LW'(q1 >> DIV3_SHIFT);
			idx2_s3 <= LW'(q2 >> DIV3_SHIFT);
			vg_s3   <= vg_s2;
			sec_s3  <= sec_s2;
		end
	end

endmodule

@@ rtl/svpwm_sine_rom.sv @@
module svpwm_sine_rom #(
	parameter int SINE_LUT_ENTRIES = 1024
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [$clog2(SINE_LUT_ENTRIES)-1:0] addr1,
	input  logic [$clog2(SINE_LUT_ENTRIES)-1:0] addr2,
	output svpwm_pkg::word16_t                 data1,
	output svpwm_pkg::word16_t                 data2
);
	import svpwm_pkg::*;

	typedef word16_t rom_t [SINE_LUT_ENTRIES];

	// quarter turn spans this many table steps, doubled
	localparam logic [63:0] TH_DEN = 64'd2 * 64'(SINE_LUT_ENTRIES);

	// quarter-wave entry: odd Taylor series to x^13 in Q30, rounded to Q16
	function automatic word16_t sine_val(int unsigned idx);
		logic [63:0] th, th2, term, sum, r;
		th   = (64'd3373259426 * 64'(idx)) / TH_DEN;
		th2  = (th * th) >> 30;
		term = th;
		sum  = th;
		term = ((term * th2) >> 30) / 64'd6;
		sum  = sum - term;
		term = ((term * th2) >> 30) / 64'd20;
		sum  = sum + term;
		term = ((term * th2) >> 30) / 64'd42;
		sum  = sum - term;
		term = ((term * th2) >> 30) / 64'd72;
		sum  = sum + term;
		term = ((term * th2) >> 30) / 64'd110;
		sum  = sum - term;
		term = ((term * th2) >> 30) / 64'd156;
		sum  = sum + term;
		r    = (sum + 64'd8192) >> 14;
		if (r > 64'd65535)
			r = 64'd65535;
		return r[15:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < SINE_LUT_ENTRIES; i++)
			t[i] = sine_val(i);
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	// two registered read ports
	always_ff @(posedge clk) begin
		if (en) begin
			data1 <= ROM[addr1];
			data2 <= ROM[addr2];
		end
	end

endmodule

@@ rtl/svpwm_duty_back.sv @@
module svpwm_duty_back (
	input  logic                clk,
	input  logic [4:0]          en,          // loads s4..s8
	input  svpwm_pkg::vg_t      vg_s3,
	input  svpwm_pkg::sec_t     sec_s3,
	input  svpwm_pkg::word16_t  sin1_s4,
	input  svpwm_pkg::word16_t  sin2_s4,
	input  svpwm_pkg::word16_t  duty_limit,
	input  svpwm_pkg::word16_t  pwm_period,
	output svpwm_pkg::word16_t  compare_a_s8,
	output svpwm_pkg::word16_t  compare_b_s8,
	output svpwm_pkg::word16_t  compare_c_s8,
	output svpwm_pkg::sec_t     sector_s8
);
	import svpwm_pkg::*;

	// doubled duty to clamped duty
	function automatic word16_t finish(logic signed [27:0] dbl, word16_t lim);
		logic [26:0] half;
		half = dbl[27] ? 27'd0 : dbl[27:1];
		if (half > 27'(lim))
			return lim;
		return half[15:0];
	endfunction

	// stage 4: align with the table read
	vg_t  vg_s4;
	sec_t sec_s4;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			vg_s4  <= vg_s3;
			sec_s4 <= sec_s3;
		end
	end

	// stage 5: gain times sine
	logic [39:0] pm1, pm2;
	logic [23:0] p1_s5, p2_s5;
	sec_t        sec_s5;

	always_comb begin
		pm1 = 40'(vg_s4) * 40'(sin1_s4);
		pm2 = 40'(vg_s4) * 40'(sin2_s4);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p1_s5  <= pm1[39:16];
			p2_s5  <= pm2[39:16];
			sec_s5 <= sec_s4;
		end
	end

	// stage 6: times sqrt3 gives the active times
	logic [40:0] tm1, tm2;
	logic [24:0] t1_s6, t2_s6;
	sec_t        sec_s6;

	always_comb begin
		tm1 = 41'(p1_s5) * 41'(SQRT3_Q16);
		tm2 = 41'(p2_s5) * 41'(SQRT3_Q16);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			t1_s6  <= tm1[40:16];
			t2_s6  <= tm2[40:16];
			sec_s6 <= sec_s5;
		end
	end

	// stage 7: sector table on doubled duties, then clamp
	logic signed [27:0] s1, s2, one, d_t0, d_sum, d_one, d_two;
	logic signed [27:0] da, db, dc;
	word16_t duty_a_s7, duty_b_s7, duty_c_s7;
	sec_t    sec_s7;

	always_comb begin
		s1    = 28'(t1_s6);
		s2    = 28'(t2_s6);
		one   = 28'(ONE_Q16);
		d_t0  = one - s1 - s2;
		d_sum = one + s1 + s2;
		d_one = one + s1 - s2;
		d_two = one - s1 + s2;
		case (sec_s6)
			3'd0: begin da = d_sum; db = d_two; dc = d_t0; end
			3'd1: begin da = d_one; db = d_sum; dc = d_t0; end
			3'd2: begin da = d_t0; db = d_sum; dc = d_two; end
			3'd3: begin da = d_t0; db = d_one; dc = d_sum; end
			3'd4: begin da = d_two; db = d_t0; dc = d_sum; end
			default: begin da = d_sum; db = d_t0; dc = d_one; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			duty_a_s7 <= finish(da, duty_limit);
			duty_b_s7 <= finish(db, duty_limit);
			duty_c_s7 <= finish(dc, duty_limit);
			sec_s7    <= sec_s6;
		end
	end

	// stage 8: scale by timer period
	logic [31:0] ca, cb, cc;

	always_comb begin
		ca = 32'(duty_a_s7) * 32'(pwm_period);
		cb = 32'(duty_b_s7) * 32'(pwm_period);
		cc = 32'(duty_c_s7) * 32'(pwm_period);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			compare_a_s8 <= ca[31:16];
			compare_b_s8 <= cb[31:16];
			compare_c_s8 <= cc[31:16];
			sector_s8    <= sec_s7 + 3'd1;
		end
	end

endmodule

@@ rtl/svpwm_duty_generator_core.sv @@
// Space-vector PWM duty generator, seven-segment pattern.
// Input stream: s_axis_tdata carries voltage_cmd (signed Q8.8) in bits 15:0
// and elec_angle (one turn = 2^ANGLE_BITS) in bits 31:16.
// Output stream: m_axis_tdata carries compare_a/b/c, m_axis_tuser the
// sector 1..6. One output word for every input word, in order.
// Config channel: cfg_valid/cfg_index/cfg_data, always ready; index 0 is
// supply_gain, 1 duty_limit, 2 pwm_period, others are dropped. Write only
// while the pipeline is empty.
// Output words come from the last of eight register stages, the first loaded
// at the input accept edge; one word per cycle sustained while m_axis_tready is high.
// The eight stages are: angle fold, gain and sector position
// multiply, divide by three, sine table read, gain times sine, times sqrt3,
// sector table and clamp, period scale.
// Reset empties the pipeline and loads the default register values.
// When m_axis_tready is low, words stack up in empty stages behind the
// output; s_axis_tready falls only once every stage holds a word.
module svpwm_duty_generator_core #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_LUT_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // voltage_cmd, elec_angle
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // compare_a, compare_b, compare_c
	output logic [2:0]  m_axis_tuser,   // sector_num
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import svpwm_pkg::*;

	localparam int LW = $clog2(SINE_LUT_ENTRIES);
	localparam int NST = 8;

	// configuration registers
	word16_t supply_gain_q, duty_limit_q, pwm_period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_gain_q <= SUPPLY_GAIN_RST;
			duty_limit_q  <= DUTY_LIMIT_RST;
			pwm_period_q  <= PWM_PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SUPPLY_GAIN: supply_gain_q <= cfg_data;
				CFG_DUTY_LIMIT:  duty_limit_q  <= cfg_data;
				CFG_PWM_PERIOD:  pwm_period_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid chain; a stage loads when it is empty or its word moves on
	logic [NST:1] vld_q;
	logic [NST:1] en;
	logic [NST:0] vin;

	always_comb begin
		en[NST] = !vld_q[NST] || m_axis_tready;
		for (int k = NST - 1; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
		vin = {vld_q, s_axis_tvalid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NST; k++)
				if (en[k])
					vld_q[k] <= vin[k-1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[NST];

	// datapath
	logic [LW-1:0] idx1_s3, idx2_s3;
	vg_t           vg_s3;
	sec_t          sec_s3;
	word16_t       sin1_s4, sin2_s4;
	word16_t       cmp_a, cmp_b, cmp_c;
	sec_t          sector_s8;

	svpwm_angle_front #(
		.ANGLE_BITS      (ANGLE_BITS),
		.SINE_LUT_ENTRIES(SINE_LUT_ENTRIES)
	) u_front (
		.clk        (clk),
		.en         (en[3:1]),
		.voltage_cmd(s_axis_tdata[15:0]),
		.elec_angle (s_axis_tdata[31:16]),
		.supply_gain(supply_gain_q),
		.idx1_s3    (idx1_s3),
		.idx2_s3    (idx2_s3),
		.vg_s3      (vg_s3),
		.sec_s3     (sec_s3)
	);

	svpwm_sine_rom #(
		.SINE_LUT_ENTRIES(SINE_LUT_ENTRIES)
	) u_rom (
		.clk  (clk),
		.en   (en[4]),
		.addr1(idx1_s3),
		.addr2(idx2_s3),
		.data1(sin1_s4),
		.data2(sin2_s4)
	);

	svpwm_duty_back u_back (
		.clk         (clk),
		.en          (en[8:4]),
		.vg_s3       (vg_s3),
		.sec_s3      (sec_s3),
		.sin1_s4     (sin1_s4),
		.sin2_s4     (sin2_s4),
		.duty_limit  (duty_limit_q),
		.pwm_period  (pwm_period_q),
		.compare_a_s8(cmp_a),
		.compare_b_s8(cmp_b),
		.compare_c_s8(cmp_c),
		.sector_s8   (sector_s8)
	);

	assign m_axis_tdata = {cmp_c, cmp_b, cmp_a};
	assign m_axis_tuser = sector_s8;

endmodule

@@ rtl/svpwm_checker.sv @@
module svpwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a waiting output word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word dropped or changed while stalled");

	// sector reported is always 1..6
	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser != 3'd0 && m_axis_tuser != 3'd7))
		else $error("sector out of range");

	// config channel never blocks
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

	// input side is only held off while the output side is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

endmodule

bind svpwm_duty_generator_core svpwm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
